>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, held off while the reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds at every rising clock edge, held off while the reset is asserted.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	`ASSERT_CLK(lbl, (cond), msg)

`endif

>>> hdl/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 10;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 48;

	// Marker keys kept in the key store.
	localparam logic [KEY_W-1:0] EMPTY_KEY = 32'h7FFF_FFFE;
	localparam logic [KEY_W-1:0] TOMB_KEY  = 32'h7FFF_FFFF;

	// Seed of the two mix registers that do not take the key.
	localparam logic [KEY_W-1:0] GOLDEN = 32'h9E37_79B9;

	// Operation codes; the unused code behaves as a find.
	localparam logic [FUNC_W-1:0] FN_FIND   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STS_MISSING  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STS_RESERVED = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

>>> hdl/lpht_mem.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read synchronous memory with registered read data.
module lpht_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/lpht_hash.sv
`timescale 1ns / 1ps

// Iterative 96-bit mix: one of the nine mix lines is applied per cycle.
module lpht_hash (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lpht_pkg::KEY_W-1:0] key,
	output logic                       done,
	output logic [lpht_pkg::KEY_W-1:0] hash
);

	localparam logic [3:0] LAST_STEP = 4'd8;

	logic [lpht_pkg::KEY_W-1:0] a_q, b_q, c_q;
	logic [lpht_pkg::KEY_W-1:0] a_d, b_d, c_d;
	logic [3:0]                 step_q;
	logic                       run_q;
	logic                       done_q;

	always_comb begin
		a_d = a_q;
		b_d = b_q;
		c_d = c_q;
		case (step_q)
			4'd0: a_d = (a_q - b_q - c_q) ^ (c_q >> 13);
			4'd1: b_d = (b_q - c_q - a_q) ^ (a_q << 8);
			4'd2: c_d = (c_q - a_q - b_q) ^ (b_q >> 13);
			4'd3: a_d = (a_q - b_q - c_q) ^ (c_q >> 12);
			4'd4: b_d = (b_q - c_q - a_q) ^ (a_q << 16);
			4'd5: c_d = (c_q - a_q - b_q) ^ (b_q >> 5);
			4'd6: a_d = (a_q - b_q - c_q) ^ (c_q >> 3);
			4'd7: b_d = (b_q - c_q - a_q) ^ (a_q << 10);
			4'd8: c_d = (c_q - a_q - b_q) ^ (b_q >> 15);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= lpht_pkg::GOLDEN;
			b_q <= lpht_pkg::GOLDEN;
			c_q <= key;
		end else if (run_q) begin
			a_q <= a_d;
			b_q <= b_d;
			c_q <= c_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			if (step_q == LAST_STEP) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	assign done = done_q;
	assign hash = c_q;

endmodule

>>> hdl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Open-addressing hash table of 32-bit keys and values with linear probing.
// Request words come in on the s_ channel: s_tuser carries the operation (find,
// insert, remove) and s_tdata carries the key and the insert value. Each request
// gives exactly one result word on the m_ channel: m_tuser carries the status and
// m_tdata carries the stored value and the slot index.
// One request is worked on at a time. A reserved key or a full table is answered
// from the idle state through the finish state, without waiting for the key mix.
// Other requests run the iterative key mix, then probe the slot memory one slot
// per cycle, visiting at least one slot. The next request is taken once the result
// has moved into the output register. The key mix and the probe loop, which
// visits one slot per cycle because of the registered memory read, set the rate.
// After reset the block sweeps the key memory, one slot per cycle, writing the
// empty marker: s_tready stays low until every slot has been written.
// A result word waits in the output register while m_tready is low; the next
// request is still taken and worked on, and its result waits for the register.
`include "assert_macros.svh"

module linear_probe_hash_table #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0 up: key (32), value_in (32).
	input  logic [lpht_pkg::S_TDATA_W-1:0]  s_tdata,
	// Fields from bit 0 up: func (2).
	input  logic [lpht_pkg::FUNC_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0 up: value_out (32), slot (10), then zero padding.
	output logic [lpht_pkg::M_TDATA_W-1:0]  m_tdata,
	// Fields from bit 0 up: status (2).
	output logic [lpht_pkg::STATUS_W-1:0]   m_tuser
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	// The table counts as full once the accepted inserts reach half of its slots.
	localparam logic [IDX_W-1:0] HALF_SLOTS = IDX_W'(TABLE_SLOTS / 2);

	lpht_pkg::state_t state_q, state_d;

	// Request held while it is being worked on.
	logic                            ins_q, rem_q;
	logic [lpht_pkg::KEY_W-1:0]      key_q;
	logic [lpht_pkg::VALUE_W-1:0]    val_q;

	// Probe index, also the address counter of the clearing sweep.
	logic [IDX_W-1:0]                idx_q, idx_d;
	logic [IDX_W-1:0]                cnt_q;
	logic                            cnt_inc;

	// Finished result, waiting to move into the output register.
	logic [lpht_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
	logic [lpht_pkg::VALUE_W-1:0]    res_value_q, res_value_d;
	logic [lpht_pkg::SLOT_W-1:0]     res_slot_q, res_slot_d;
	logic                            res_load;

	logic                            m_tvalid_q;
	logic [lpht_pkg::M_TDATA_W-1:0]  m_tdata_q;
	logic [lpht_pkg::STATUS_W-1:0]   m_tuser_q;
	logic                            out_load;

	// Memory ports.
	logic [IDX_W-1:0]                rd_addr;
	logic                            kwe, vwe;
	logic [lpht_pkg::KEY_W-1:0]      kwdata;
	logic [lpht_pkg::KEY_W-1:0]      k_rdata;
	logic [lpht_pkg::VALUE_W-1:0]    v_rdata;

	// Hash unit.
	logic                            hash_start;
	logic                            hash_done;
	logic [lpht_pkg::KEY_W-1:0]      hash_val;
	logic [IDX_W-1:0]                hash_idx;

	// Request fields on the input channel.
	logic [lpht_pkg::KEY_W-1:0]      in_key;
	logic [lpht_pkg::VALUE_W-1:0]    in_val;
	logic                            in_reserved;
	logic                            in_insert;

	// The slot field is the low bits of the index, zero-extended for small tables.
	logic [IDX_W+lpht_pkg::SLOT_W-1:0] slot_wide;

	assign in_key      = s_tdata[lpht_pkg::KEY_W-1:0];
	assign in_val      = s_tdata[lpht_pkg::KEY_W +: lpht_pkg::VALUE_W];
	assign in_reserved = (in_key == lpht_pkg::EMPTY_KEY) || (in_key == lpht_pkg::TOMB_KEY);
	assign in_insert   = (s_tuser == lpht_pkg::FN_INSERT);
	assign hash_idx    = hash_val[IDX_W-1:0];
	assign slot_wide   = {{lpht_pkg::SLOT_W{1'b0}}, idx_q};

	lpht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (in_key),
		.done   (hash_done),
		.hash   (hash_val)
	);

	lpht_mem #(
		.DEPTH (TABLE_SLOTS),
		.WIDTH (lpht_pkg::KEY_W)
	) u_keys (
		.clk   (clk),
		.we    (kwe),
		.waddr (idx_q),
		.wdata (kwdata),
		.raddr (rd_addr),
		.rdata (k_rdata)
	);

	lpht_mem #(
		.DEPTH (TABLE_SLOTS),
		.WIDTH (lpht_pkg::VALUE_W)
	) u_values (
		.clk   (clk),
		.we    (vwe),
		.waddr (idx_q),
		.wdata (val_q),
		.raddr (rd_addr),
		.rdata (v_rdata)
	);

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		hash_start   = 1'b0;
		rd_addr      = idx_q;
		idx_d        = idx_q;
		kwe          = 1'b0;
		kwdata       = lpht_pkg::EMPTY_KEY;
		vwe          = 1'b0;
		cnt_inc      = 1'b0;
		res_load     = 1'b0;
		res_status_d = lpht_pkg::STS_MISSING;
		res_value_d  = '0;
		res_slot_d   = '0;
		out_load     = 1'b0;
		unique case (state_q)
			lpht_pkg::ST_CLEAR: begin
				// Sweep writes the empty marker into every slot.
				kwe   = 1'b1;
				idx_d = idx_q + IDX_W'(1);
				if (idx_q == {IDX_W{1'b1}}) begin
					state_d = lpht_pkg::ST_IDLE;
				end
			end
			lpht_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					hash_start = 1'b1;
					if (in_reserved) begin
						res_load     = 1'b1;
						res_status_d = lpht_pkg::STS_RESERVED;
						state_d      = lpht_pkg::ST_FINISH;
					end else if (in_insert && (cnt_q >= HALF_SLOTS)) begin
						res_load     = 1'b1;
						res_status_d = lpht_pkg::STS_FULL;
						state_d      = lpht_pkg::ST_FINISH;
					end else begin
						state_d = lpht_pkg::ST_HASH;
					end
				end
			end
			lpht_pkg::ST_HASH: begin
				if (hash_done) begin
					rd_addr = hash_idx;
					idx_d   = hash_idx;
					state_d = lpht_pkg::ST_CHECK;
				end
			end
			lpht_pkg::ST_CHECK: begin
				// The key and value of slot idx_q are on the read ports; the read of
				// the next slot is issued in the same cycle in case the probe goes on.
				rd_addr = idx_q + IDX_W'(1);
				if (ins_q) begin
					if ((k_rdata == lpht_pkg::EMPTY_KEY) || (k_rdata == lpht_pkg::TOMB_KEY) ||
						(k_rdata == key_q)) begin
						kwe          = 1'b1;
						kwdata       = key_q;
						vwe          = 1'b1;
						cnt_inc      = 1'b1;
						res_load     = 1'b1;
						res_status_d = lpht_pkg::STS_DONE;
						res_slot_d   = slot_wide[lpht_pkg::SLOT_W-1:0];
						state_d      = lpht_pkg::ST_FINISH;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end else if (k_rdata == lpht_pkg::EMPTY_KEY) begin
					res_load     = 1'b1;
					res_status_d = lpht_pkg::STS_MISSING;
					state_d      = lpht_pkg::ST_FINISH;
				end else if (k_rdata == key_q) begin
					// A remove leaves a tombstone in place of the key.
					kwe          = rem_q;
					kwdata       = lpht_pkg::TOMB_KEY;
					res_load     = 1'b1;
					res_status_d = lpht_pkg::STS_DONE;
					res_value_d  = v_rdata;
					res_slot_d   = slot_wide[lpht_pkg::SLOT_W-1:0];
					state_d      = lpht_pkg::ST_FINISH;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			lpht_pkg::ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = lpht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpht_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lpht_pkg::ST_CLEAR;
			idx_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ins_q <= in_insert;
			rem_q <= (s_tuser == lpht_pkg::FN_REMOVE);
			key_q <= in_key;
			val_q <= in_val;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_value_q  <= res_value_d;
			res_slot_q   <= res_slot_d;
		end
		if (out_load) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= lpht_pkg::M_TDATA_W'({res_slot_q, res_value_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The insert counter never passes the load limit.
	`ASSERT_ALWAYS(a_load_limit, cnt_q <= HALF_SLOTS, "insert counter beyond half the table")
	// Only one request is in flight: a taken word drops ready in the next cycle.
	`ASSERT_CLK(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready,
		"second request taken")
	// No result appears while the key memory is still being swept.
	`ASSERT_CLK(a_quiet_clear, (state_q == lpht_pkg::ST_CLEAR) |-> !m_tvalid,
		"result during sweep")
	// A write during probing always ends the probe.
	`ASSERT_CLK(a_write_ends_probe,
		(kwe && (state_q == lpht_pkg::ST_CHECK)) |=> (state_q == lpht_pkg::ST_FINISH),
		"probe went on after write")

endmodule

>>> verif/linear_probe_hash_table_test.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_test;

	localparam int TABLE_SLOTS = 1024;
	localparam int POOL_SIZE   = 40;
	// The fourth operation code has no name in the package; the block treats it as a find.
	localparam logic [lpht_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

	// One result word as the table reports it.
	typedef struct packed {
		logic [lpht_pkg::STATUS_W-1:0] status;
		logic [lpht_pkg::VALUE_W-1:0]  value;
		logic [lpht_pkg::SLOT_W-1:0]   slot;
	} table_result_t;

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [lpht_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
	logic [lpht_pkg::FUNC_W-1:0]      s_tuser  = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [lpht_pkg::M_TDATA_W-1:0]   m_tdata;
	logic [lpht_pkg::STATUS_W-1:0]    m_tuser;

	// Shadow copy of the table contents, updated as each request word is accepted.
	logic [lpht_pkg::KEY_W-1:0]       shadow_keys [TABLE_SLOTS];
	logic [lpht_pkg::VALUE_W-1:0]     shadow_values [TABLE_SLOTS];
	int unsigned                      shadow_inserts = 0;

	// Results still owed by the block, oldest first.
	table_result_t                    owed_results [$];
	logic [lpht_pkg::KEY_W-1:0]       key_pool [POOL_SIZE];

	int unsigned            send_idle_pct  = 0;
	int unsigned            recv_stall_pct = 0;
	int unsigned            hold_request   = 0;
	int unsigned            hold_left      = 0;
	int unsigned            requests_sent  = 0;
	int unsigned            status_seen [4] = '{0, 0, 0, 0};
	int unsigned            failures       = 0;

	linear_probe_hash_table #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Fixed ceiling on the run. The slowest correct run is the reset sweep plus
	// about a thousand requests, each with a long probe and stalls on both sides,
	// which stays well under a tenth of this.
	initial begin
		#12_000_000;
		$display("FAIL");
		$finish;
	end

	// Jenkins 96-bit mix with a and b seeded by the golden ratio and c by the key.
	function automatic logic [lpht_pkg::KEY_W-1:0] key_mix(
			input logic [lpht_pkg::KEY_W-1:0] key);
		logic [lpht_pkg::KEY_W-1:0] a;
		logic [lpht_pkg::KEY_W-1:0] b;
		logic [lpht_pkg::KEY_W-1:0] c;
		a = lpht_pkg::GOLDEN;
		b = lpht_pkg::GOLDEN;
		c = key;
		a = a - b; a = a - c; a = a ^ (c >> 13);
		b = b - c; b = b - a; b = b ^ (a << 8);
		c = c - a; c = c - b; c = c ^ (b >> 13);
		a = a - b; a = a - c; a = a ^ (c >> 12);
		b = b - c; b = b - a; b = b ^ (a << 16);
		c = c - a; c = c - b; c = c ^ (b >> 5);
		a = a - b; a = a - c; a = a ^ (c >> 3);
		b = b - c; b = b - a; b = b ^ (a << 10);
		c = c - a; c = c - b; c = c ^ (b >> 15);
		return c;
	endfunction

	function automatic int unsigned home_slot(input logic [lpht_pkg::KEY_W-1:0] key);
		return key_mix(key) & (TABLE_SLOTS - 1);
	endfunction

	// Searches upward from a random key for an ordinary key whose probe starts at
	// the given slot, so that collisions and wrap-around can be set up on purpose.
	function automatic logic [lpht_pkg::KEY_W-1:0] key_for_slot(input int unsigned slot);
		logic [lpht_pkg::KEY_W-1:0] key;
		key = $urandom;
		while (home_slot(key) != slot || key == lpht_pkg::EMPTY_KEY ||
				key == lpht_pkg::TOMB_KEY)
			key = key + 1;
		return key;
	endfunction

	// Applies one request to the shadow table and returns the result it must give.
	function automatic table_result_t apply_request(input logic [lpht_pkg::FUNC_W-1:0] fn,
			input logic [lpht_pkg::KEY_W-1:0] key, input logic [lpht_pkg::VALUE_W-1:0] val);
		table_result_t res;
		int unsigned   idx;
		int unsigned   n;
		logic [lpht_pkg::KEY_W-1:0] held;
		res.status = lpht_pkg::STS_MISSING;
		res.value  = '0;
		res.slot   = '0;
		idx        = home_slot(key);
		if (key == lpht_pkg::EMPTY_KEY || key == lpht_pkg::TOMB_KEY) begin
			res.status = lpht_pkg::STS_RESERVED;
		end else if (fn == lpht_pkg::FN_INSERT) begin
			res.status = lpht_pkg::STS_FULL;
			// The load limit counts accepted inserts; removes never give one back.
			if (2 * shadow_inserts < TABLE_SLOTS) begin
				for (n = 0; n < TABLE_SLOTS; n++) begin
					held = shadow_keys[idx];
					if (held == lpht_pkg::EMPTY_KEY || held == lpht_pkg::TOMB_KEY ||
							held == key) begin
						shadow_keys[idx]   = key;
						shadow_values[idx] = val;
						shadow_inserts++;
						res.status = lpht_pkg::STS_DONE;
						res.slot   = idx[lpht_pkg::SLOT_W-1:0];
						break;
					end
					idx = (idx + 1) % TABLE_SLOTS;
				end
			end
		end else begin
			// Find, remove and the unused code walk past tombstones up to an empty slot.
			for (n = 0; n < TABLE_SLOTS; n++) begin
				held = shadow_keys[idx];
				if (held == lpht_pkg::EMPTY_KEY)
					break;
				if (held == key) begin
					res.status = lpht_pkg::STS_DONE;
					res.value  = shadow_values[idx];
					res.slot   = idx[lpht_pkg::SLOT_W-1:0];
					if (fn == lpht_pkg::FN_REMOVE)
						shadow_keys[idx] = lpht_pkg::TOMB_KEY;
					break;
				end
				idx = (idx + 1) % TABLE_SLOTS;
			end
		end
		return res;
	endfunction

	// Offers one request word, starting and ending at a falling edge. s_tvalid is
	// left high so that back-to-back words need no drop in between.
	task automatic send_request(input logic [lpht_pkg::FUNC_W-1:0] fn,
			input logic [lpht_pkg::KEY_W-1:0] key, input logic [lpht_pkg::VALUE_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = fn;
		s_tdata  = {val, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		owed_results.push_back(apply_request(fn, key, val));
		requests_sent++;
		@(negedge clk);
	endtask

	// Stops offering words and waits for every owed result.
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_random_item();
		int unsigned                 pick;
		logic [lpht_pkg::FUNC_W-1:0] fn;
		logic [lpht_pkg::KEY_W-1:0]  key;
		pick = $urandom_range(99);
		if (pick < 35)
			fn = lpht_pkg::FN_INSERT;
		else if (pick < 70)
			fn = lpht_pkg::FN_FIND;
		else if (pick < 95)
			fn = lpht_pkg::FN_REMOVE;
		else
			fn = FN_UNUSED;
		// Mostly keys from the pool, so that finds and removes hit and clusters form.
		pick = $urandom_range(99);
		if (pick < 80)
			key = key_pool[$urandom_range(POOL_SIZE - 1)];
		else if (pick < 95)
			key = $urandom;
		else
			key = pick[0] ? lpht_pkg::TOMB_KEY : lpht_pkg::EMPTY_KEY;
		send_request(fn, key, $urandom);
	endtask

	task automatic test_basic_ops();
		send_request(lpht_pkg::FN_FIND, 32'h0000_0000, 32'h1234_5678);
		send_request(lpht_pkg::FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(lpht_pkg::FN_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(lpht_pkg::FN_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lpht_pkg::FN_FIND, 32'h0000_0000, 32'h0);
		send_request(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// A second insert of a held key overwrites its value in place.
		send_request(lpht_pkg::FN_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
		send_request(lpht_pkg::FN_FIND, 32'h0000_0000, 32'h0);
		drain_results();
	endtask

	task automatic test_reserved_keys();
		send_request(lpht_pkg::FN_INSERT, lpht_pkg::EMPTY_KEY, 32'hDEAD_BEEF);
		send_request(lpht_pkg::FN_FIND, lpht_pkg::TOMB_KEY, 32'h0);
		send_request(lpht_pkg::FN_REMOVE, lpht_pkg::EMPTY_KEY, 32'h0);
		send_request(FN_UNUSED, lpht_pkg::TOMB_KEY, 32'h0);
		drain_results();
	endtask

	// Two keys share a home slot. After the first is removed, a new insert of the
	// second lands on the tombstone ahead of its older copy, so the key is held
	// twice; removing the front copy uncovers the old one.
	task automatic test_tombstone_reuse();
		int unsigned                home;
		logic [lpht_pkg::KEY_W-1:0] first_key;
		logic [lpht_pkg::KEY_W-1:0] second_key;
		home      = $urandom_range(1, 1000);
		first_key = key_for_slot(home);
		do
			second_key = key_for_slot(home);
		while (second_key == first_key);
		send_request(lpht_pkg::FN_INSERT, first_key, 32'h1111_1111);
		send_request(lpht_pkg::FN_INSERT, second_key, 32'h2222_2222);
		send_request(lpht_pkg::FN_REMOVE, first_key, 32'h0);
		send_request(lpht_pkg::FN_FIND, second_key, 32'h0);
		send_request(lpht_pkg::FN_INSERT, second_key, 32'h3333_3333);
		send_request(lpht_pkg::FN_FIND, second_key, 32'h0);
		send_request(lpht_pkg::FN_REMOVE, second_key, 32'h0);
		send_request(lpht_pkg::FN_FIND, second_key, 32'h0);
		drain_results();
	endtask

	// Two keys with their home in the last slot: the second probe wraps to slot 0.
	task automatic test_wraparound();
		logic [lpht_pkg::KEY_W-1:0] first_key;
		logic [lpht_pkg::KEY_W-1:0] second_key;
		first_key = key_for_slot(TABLE_SLOTS - 1);
		do
			second_key = key_for_slot(TABLE_SLOTS - 1);
		while (second_key == first_key);
		send_request(lpht_pkg::FN_INSERT, first_key, 32'h0F0F_0F0F);
		send_request(lpht_pkg::FN_INSERT, second_key, 32'hF0F0_F0F0);
		send_request(lpht_pkg::FN_FIND, second_key, 32'h0);
		drain_results();
	endtask

	// Pool of keys: some loose ones and a few clusters that share or neighbor a
	// home slot, so that probes run across several slots and tombstones.
	task automatic build_key_pool();
		int unsigned base;
		int unsigned i;
		base = $urandom_range(0, TABLE_SLOTS - 2);
		for (i = 0; i < POOL_SIZE; i++) begin
			if (i < 16)
				key_pool[i] = $urandom;
			else if (i < 22)
				key_pool[i] = key_for_slot(base);
			else if (i < 28)
				key_pool[i] = key_for_slot(base + 1);
			else if (i < 34)
				key_pool[i] = key_for_slot(100);
			else
				key_pool[i] = key_for_slot(TABLE_SLOTS - 1);
		end
	endtask

	task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned i;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (i = 0; i < count; i++)
			send_random_item();
		drain_results();
	endtask

	task automatic test_random_mix();
		build_key_pool();
		run_random_phase(110, 0, 0);
		run_random_phase(110, 59, 0);
		run_random_phase(110, 0, 59);
		run_random_phase(110, 12, 12);
	endtask

	// The receiver holds m_tready low for a long stretch while words keep coming,
	// so the output register and the request in flight fill and s_tready drops.
	task automatic test_output_backpressure();
		int unsigned i;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_request = 300;
		@(negedge clk);
		for (i = 0; i < 10; i++)
			send_random_item();
		drain_results();
	endtask

	// Fresh keys until the insert count reaches half the table, then inserts of ordinary
	// keys that must report full, while finds and removes keep working.
	task automatic test_table_full();
		int unsigned                i;
		logic [lpht_pkg::KEY_W-1:0] key;
		send_idle_pct  = 12;
		recv_stall_pct = 12;
		while (2 * shadow_inserts < TABLE_SLOTS) begin
			do
				key = $urandom;
			while (key == lpht_pkg::EMPTY_KEY || key == lpht_pkg::TOMB_KEY);
			send_request(lpht_pkg::FN_INSERT, key, $urandom);
		end
		for (i = 0; i < 6; i++)
			send_request(lpht_pkg::FN_INSERT, key_pool[$urandom_range(POOL_SIZE - 1)],
				$urandom);
		send_request(lpht_pkg::FN_INSERT, lpht_pkg::EMPTY_KEY, $urandom);
		for (i = 0; i < 30; i++)
			send_random_item();
		drain_results();
	endtask

	// The receiver side: a long hold when one is asked for, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			m_tready  = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every accepted result word is checked against the oldest owed result.
	always @(posedge clk) begin : result_check
		table_result_t want;
		table_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.value  = m_tdata[lpht_pkg::VALUE_W-1:0];
			got.slot   = m_tdata[lpht_pkg::VALUE_W +: lpht_pkg::SLOT_W];
			status_seen[got.status]++;
			if (m_tdata[lpht_pkg::M_TDATA_W-1:lpht_pkg::VALUE_W+lpht_pkg::SLOT_W] !== '0) begin
				$display("%0t: padding bits expected 0, got %h", $time,
					m_tdata[lpht_pkg::M_TDATA_W-1:lpht_pkg::VALUE_W+lpht_pkg::SLOT_W]);
				failures++;
			end
			if (owed_results.size() == 0) begin
				$display("%0t: result word with none expected: status %0d value %h slot %0d",
					$time, got.status, got.value, got.slot);
				failures++;
			end else begin
				want = owed_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status,
						got.status);
					failures++;
				end
				if (got.value !== want.value) begin
					$display("%0t: value_out expected %h, got %h", $time, want.value,
						got.value);
					failures++;
				end
				if (got.slot !== want.slot) begin
					$display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
					failures++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			shadow_keys[i]   = lpht_pkg::EMPTY_KEY;
			shadow_values[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		// The block sweeps its key store after reset; the first word simply waits
		// for s_tready.
		test_basic_ops();
		test_reserved_keys();
		test_tombstone_reuse();
		test_wraparound();
		test_random_mix();
		test_output_backpressure();
		test_table_full();
		drain_results();
		// A result word beyond the last expected one would show up within this time.
		repeat (200) @(negedge clk);
		if (owed_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, owed_results.size());
			failures++;
		end
		$display("Sent %0d requests; results seen: %0d done, %0d missing, %0d full, %0d reserved.",
			requests_sent, status_seen[lpht_pkg::STS_DONE], status_seen[lpht_pkg::STS_MISSING],
			status_seen[lpht_pkg::STS_FULL], status_seen[lpht_pkg::STS_RESERVED]);
		$display("Inserts accepted %0d of a limit of %0d; %0d mismatches.",
			shadow_inserts, TABLE_SLOTS / 2, failures);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
